// ===== sv/u16u8_pkg.sv =====
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies.
package u16u8_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int MAX_RESULTS      = 6;
    localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // One code point, encoded: bytes in send order, byte 0 first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } enc_t;

    function automatic enc_t utf8_enc(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp < 21'h80) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end else if (cp < 21'h800) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end else if (cp < 21'h10000) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

// ===== sv/utf16_to_utf8_transcoder.sv =====
// UTF-16 byte stream to UTF-8 byte stream transcoder, top level.
// Depends on u16u8_pkg (types, encoder function, constants).
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | sink      | in_valid / in_stall   | opcode, data_byte
//  out     | source    | out_valid / out_stall | out_byte, source_offset, last
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_data (big_endian bit)
//
// Flow: an accepted item waits in the input register, is decoded there and its
// 0..6 result bytes load into the result buffer at the next edge that frees it, so
// bytes pass the input register and then the result buffer before they reach out.
// The result buffer sends one byte per cycle while out_stall is low. A first byte
// makes no result byte, a unit up to 4, and up to 6 when a broken surrogate pair is
// flushed. Items that make no byte never wait.
// Reset clears phase, pending surrogate, counter, valids and big_endian.
// A stall on out holds the buffer; an item with bytes then waits in the input register and in_stall rises.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  data_byte,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [31:0] source_offset,
    output logic        last,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    // ---------------- configuration ----------------
    logic big_endian_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            big_endian_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            big_endian_reg <= cfg_data;
    end

    // ---------------- input register (skid for the result buffer) ----------------
    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] byte_reg;
    logic       load;

    assign in_stall = in_valid_reg && !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= opcode;
            byte_reg <= data_byte;
        end
    end

    // ---------------- stream state ----------------
    logic                    phase_reg,   phase_next;
    logic [7:0]              held_reg,    held_next;
    logic                    pend_reg,    pend_next;
    logic [9:0]              sbits_reg,   sbits_next;
    logic [31:0]             soff_reg,    soff_next;
    logic [OFFSET_WIDTH-1:0] count_reg,   count_next;

    // ---------------- decode of the item in the input register ----------------
    logic [15:0]             unit;
    logic [OFFSET_WIDTH-1:0] start;
    logic [63:0]             start_wide;
    logic [31:0]             start32;
    logic                    is_high;
    logic                    is_low;
    enc_t                    enc_a;      // bytes sent with the first offset
    enc_t                    enc_b;      // bytes sent with the second offset
    logic [2:0]              len_a;
    logic [2:0]              len_b;
    logic [31:0]             off_a;
    logic [31:0]             off_b;
    logic [RES_CNT_W-1:0]    new_cnt;
    logic [7:0]              new_bytes [MAX_RESULTS];

    assign unit       = big_endian_reg ? {held_reg, byte_reg} : {byte_reg, held_reg};
    assign start      = count_reg - OFFSET_WIDTH'(1);
    assign start_wide = 64'(start);
    assign start32    = start_wide[31:0];
    assign is_high    = (unit >= 16'hD800) && (unit <= 16'hDBFF);
    assign is_low     = (unit >= 16'hDC00) && (unit <= 16'hDFFF);

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        sbits_next = sbits_reg;
        soff_next  = soff_reg;
        count_next = count_reg;
        enc_a      = utf8_enc({5'd0, 6'b110110, sbits_reg});
        enc_b      = utf8_enc({5'd0, unit});
        len_a      = 3'd0;
        len_b      = 3'd0;
        off_a      = soff_reg;
        off_b      = start32;

        if (op_reg == OP_END)
        begin
            // flush a held high surrogate on its own, drop an odd byte
            if (pend_reg)
                len_a = enc_a.len;
            pend_next  = 1'b0;
            phase_next = 1'b0;
            count_next = '0;
        end
        else if (!phase_reg)
        begin
            held_next  = byte_reg;
            phase_next = 1'b1;
            count_next = count_reg + OFFSET_WIDTH'(1);
        end
        else
        begin
            phase_next = 1'b0;
            count_next = count_reg + OFFSET_WIDTH'(1);
            if (pend_reg && is_low)
            begin
                // surrogate pair: one supplementary code point
                enc_a     = utf8_enc(21'h10000 + {1'b0, sbits_reg, unit[9:0]});
                len_a     = enc_a.len;
                pend_next = 1'b0;
            end
            else
            begin
                if (pend_reg)
                begin
                    len_a     = enc_a.len;
                    pend_next = 1'b0;
                end
                if (is_high)
                begin
                    pend_next  = 1'b1;
                    sbits_next = unit[9:0];
                    soff_next  = start32;
                end
                else
                    len_b = enc_b.len;
            end
        end
    end

    always_comb
    begin
        logic [2:0] idx;
        new_cnt = RES_CNT_W'(len_a + len_b);
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            idx = 3'(i) - len_a;
            if (3'(i) < len_a)
                new_bytes[i] = enc_a.bytes[2'(i)];
            else if (idx < 3'd4)
                new_bytes[i] = enc_b.bytes[idx[1:0]];
            else
                new_bytes[i] = 8'h00;
        end
    end

    // ---------------- result buffer ----------------
    logic [7:0]           buf_reg  [MAX_RESULTS];
    logic [7:0]           buf_next [MAX_RESULTS];
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;   // bytes left to send
    logic [RES_CNT_W-1:0] na_reg,  na_next;    // of those, bytes that use off_a
    logic [31:0]          offa_reg, offa_next;
    logic [31:0]          offb_reg, offb_next;
    logic                 pop;
    logic                 buf_free;

    assign out_valid     = (cnt_reg != '0);
    assign out_byte      = buf_reg[0];
    assign source_offset = (na_reg != '0) ? offa_reg : offb_reg;
    assign last          = (cnt_reg == RES_CNT_W'(1));
    assign pop           = out_valid && !out_stall;
    assign buf_free      = (cnt_reg == '0) || (last && pop);
    // an item with no bytes only touches the stream state
    assign load          = in_valid_reg && (buf_free || (new_cnt == '0));

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        na_next   = na_reg;
        offa_next = offa_reg;
        offb_next = offb_reg;
        if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                buf_next[i] = buf_reg[i + 1];
            buf_next[MAX_RESULTS - 1] = 8'h00;
            cnt_next = cnt_reg - RES_CNT_W'(1);
            if (na_reg != '0)
                na_next = na_reg - RES_CNT_W'(1);
        end
        if (load && (new_cnt != '0))
        begin
            buf_next  = new_bytes;
            cnt_next  = new_cnt;
            na_next   = RES_CNT_W'(len_a);
            offa_next = off_a;
            offb_next = off_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            na_reg    <= '0;
            phase_reg <= 1'b0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            na_reg  <= na_next;
            if (load)
            begin
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        offa_reg <= offa_next;
        offb_reg <= offb_next;
        if (load)
        begin
            held_reg  <= held_next;
            sbits_reg <= sbits_next;
            soff_reg  <= soff_next;
        end
    end

`ifndef SYNTHESIS
    // first-offset bytes never outnumber bytes left
    a_na_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        na_reg <= cnt_reg)
        else $error("offset split count exceeds buffered bytes");

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result buffer overfilled");

    // a load with bytes never overwrites unsent bytes
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (new_cnt != '0)) |->
            ((cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && !out_stall)))
        else $error("result buffer overwritten");

    // a held result stays while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte)
            && $stable(source_offset)))
        else $error("stalled result changed");
`endif

endmodule
